/* design/mtdb_pkg.sv */
`timescale 1ns / 1ps
package mtdb_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int ADDR_TIMERS    = 16;
	localparam logic [4:0] NONE_ID = 5'd16;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_REL   = 3'd1,
		ACT_ABS   = 3'd2,
		ACT_STOP  = 3'd3,
		ACT_QUERY = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_EXPIRY = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pending;
		logic out_free;
	} status_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* design/multi_timer_deadline_bank.sv */
`timescale 1ns / 1ps
// Bank of one-shot/periodic timers on a seconds clock. Each request (tick, start
// relative, start absolute, stop, query) is taken one at a time: it is captured,
// then applied, then one pass through the timer entries (at most 16) handles expiry
// on a tick and finds the earliest deadline, then the results are delivered one at
// a time, each held while out_stall is high.
// Timers are addressed 0..15; min(NUM_TIMERS,16) entries are built.
module multi_timer_deadline_bank import mtdb_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [3:0]  timer_id,
	input  logic [15:0] seconds,
	input  logic        one_shot,
	input  logic [31:0] deadline,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  fired_id,
	output logic [31:0] fire_time,
	output logic        is_active,
	output logic        accepted,
	output logic [4:0]  earliest_id,
	output logic        last
);

	localparam int BANK = (NUM_TIMERS < ADDR_TIMERS) ? NUM_TIMERS : ADDR_TIMERS;

	cmd_t    cmd;
	status_t st;

	mtdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	mtdb_datapath #(.BANK(BANK)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (action),
		.timer_id    (timer_id),
		.seconds     (seconds),
		.one_shot    (one_shot),
		.deadline    (deadline),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.fired_id    (fired_id),
		.fire_time   (fire_time),
		.is_active   (is_active),
		.accepted    (accepted),
		.earliest_id (earliest_id),
		.last        (last)
	);

endmodule

/* design/mtdb_ctrl.sv */
`timescale 1ns / 1ps
module mtdb_ctrl import mtdb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!st.pending) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* design/mtdb_datapath.sv */
`timescale 1ns / 1ps
module mtdb_datapath import mtdb_pkg::*; #(
	parameter int BANK = NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic [2:0]  action,
	input  logic [3:0]  timer_id,
	input  logic [15:0] seconds,
	input  logic        one_shot,
	input  logic [31:0] deadline,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  fired_id,
	output logic [31:0] fire_time,
	output logic        is_active,
	output logic        accepted,
	output logic [4:0]  earliest_id,
	output logic        last
);

	localparam int IW = (BANK > 1) ? $clog2(BANK) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(BANK - 1);

	logic [31:0] now_q;
	logic [BANK-1:0] act_q;
	logic [31:0] dl_q [BANK];
	logic [15:0] per_q [BANK];
	logic        single_q [BANK];
	logic [4:0]  earliest_q;

	logic [2:0]  action_q;
	logic [3:0]  id_q;
	logic [15:0] secs_q;
	logic        shot_q;
	logic [31:0] dlin_q;

	logic [IW-1:0] idx_q;
	logic          best_none_q;
	logic [IW-1:0] best_q;
	logic [31:0]   best_dl_q;
	logic [BANK-1:0] fired_q, fired_act_q;
	logic        cmd_pend_q;
	logic [1:0]  cmd_kind_q;
	logic        cmd_act_q, cmd_acc_q;

	logic        out_valid_q, last_q, is_active_q, accepted_q;
	logic [1:0]  kind_q;
	logic [3:0]  fired_id_q;
	logic [31:0] fire_time_q;
	logic [4:0]  earliest_id_q;

	logic          id_ok;
	logic [IW-1:0] id_ix;
	logic          is_tick;
	logic          fire, new_act;
	logic [31:0]   new_dl;
	logic          take_best;
	logic [IW-1:0] low_ix;
	logic [BANK-1:0] low_oh;

	assign id_ok   = {1'b0, id_q} < 5'(BANK);
	assign id_ix   = id_q[IW-1:0];
	assign is_tick = action_q == ACT_TICK;

	// per-entry update during the scan pass
	always_comb begin
		fire      = is_tick && act_q[idx_q] && (dl_q[idx_q] <= now_q);
		new_act   = fire ? !single_q[idx_q] : act_q[idx_q];
		new_dl    = (fire && !single_q[idx_q]) ?
			sat_add(dl_q[idx_q], {16'd0, per_q[idx_q]}) : dl_q[idx_q];
		take_best = new_act && (best_none_q || (new_dl < best_dl_q));
	end

	always_comb begin
		low_ix = '0;
		low_oh = '0;
		for (int i = BANK - 1; i >= 0; i--) begin
			if (fired_q[i]) begin
				low_ix = IW'(i);
			end
		end
		low_oh[low_ix] = fired_q[low_ix];
	end

	assign st.scan_last = idx_q == LAST_IDX;
	assign st.pending   = cmd_pend_q || (|fired_q);
	assign st.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			act_q       <= '0;
			earliest_q  <= NONE_ID;
			fired_q     <= '0;
			cmd_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cmd.capture) begin
				action_q <= action;
				id_q     <= timer_id;
				secs_q   <= seconds;
				shot_q   <= one_shot;
				dlin_q   <= deadline;
			end
			if (cmd.exec) begin
				idx_q       <= '0;
				best_none_q <= 1'b1;
				fired_q     <= '0;
				cmd_pend_q  <= 1'b0;
				case (action_q)
					ACT_TICK: now_q <= now_q + 32'd1;
					ACT_REL: begin
						cmd_pend_q <= 1'b1;
						cmd_kind_q <= KIND_ACK;
						cmd_act_q  <= id_ok;
						cmd_acc_q  <= id_ok;
						if (id_ok) begin
							dl_q[id_ix]     <= sat_add(now_q, {16'd0, secs_q});
							per_q[id_ix]    <= secs_q;
							single_q[id_ix] <= shot_q;
							act_q[id_ix]    <= 1'b1;
						end
					end
					ACT_ABS: begin
						cmd_pend_q <= 1'b1;
						cmd_kind_q <= KIND_ACK;
						cmd_acc_q  <= id_ok && (dlin_q > now_q);
						cmd_act_q  <= id_ok && ((dlin_q > now_q) || act_q[id_ix]);
						if (id_ok && (dlin_q > now_q)) begin
							dl_q[id_ix]     <= dlin_q;
							per_q[id_ix]    <= '0;
							single_q[id_ix] <= 1'b1;
							act_q[id_ix]    <= 1'b1;
						end
					end
					ACT_STOP: begin
						cmd_pend_q <= 1'b1;
						cmd_kind_q <= KIND_ACK;
						cmd_act_q  <= 1'b0;
						cmd_acc_q  <= id_ok;
						if (id_ok) act_q[id_ix] <= 1'b0;
					end
					ACT_QUERY: begin
						cmd_pend_q <= 1'b1;
						cmd_kind_q <= KIND_QUERY;
						cmd_act_q  <= id_ok && act_q[id_ix];
						cmd_acc_q  <= id_ok;
					end
					default: ;
				endcase
			end
			if (cmd.scan) begin
				act_q[idx_q]       <= new_act;
				dl_q[idx_q]        <= new_dl;
				fired_q[idx_q]     <= fire;
				fired_act_q[idx_q] <= new_act;
				if (take_best) begin
					best_none_q <= 1'b0;
					best_q      <= idx_q;
					best_dl_q   <= new_dl;
				end
				if (idx_q == LAST_IDX) begin
					idx_q <= '0;
					if (take_best) earliest_q <= 5'(idx_q);
					else if (best_none_q) earliest_q <= NONE_ID;
					else earliest_q <= 5'(best_q);
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q   <= 1'b1;
				fire_time_q   <= now_q;
				earliest_id_q <= earliest_q;
				if (cmd_pend_q) begin
					cmd_pend_q  <= 1'b0;
					kind_q      <= cmd_kind_q;
					fired_id_q  <= id_q;
					is_active_q <= cmd_act_q;
					accepted_q  <= cmd_acc_q;
					last_q      <= 1'b1;
				end else begin
					fired_q     <= fired_q & ~low_oh;
					kind_q      <= KIND_EXPIRY;
					fired_id_q  <= 4'(low_ix);
					is_active_q <= fired_act_q[low_ix];
					accepted_q  <= 1'b1;
					last_q      <= (fired_q & ~low_oh) == '0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign fired_id    = fired_id_q;
	assign fire_time   = fire_time_q;
	assign is_active   = is_active_q;
	assign accepted    = accepted_q;
	assign earliest_id = earliest_id_q;
	assign last        = last_q;

endmodule

/* design/mtdb_checker.sv */
`timescale 1ns / 1ps
module mtdb_checker import mtdb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [31:0] fire_time,
	input logic        accepted,
	input logic [4:0]  earliest_id,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fire_time) && $stable(kind))
		else $error("stalled result changed");

	a_expiry_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EXPIRY |-> accepted)
		else $error("expiry without accepted");

	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACK || kind == KIND_QUERY) |-> last)
		else $error("command result not last");

	a_earliest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> earliest_id <= NONE_ID)
		else $error("earliest id out of range");

endmodule

bind multi_timer_deadline_bank mtdb_checker u_mtdb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.fire_time   (fire_time),
	.accepted    (accepted),
	.earliest_id (earliest_id),
	.last        (last)
);
